### rtl/shs_pkg.sv
// Shared types, constants and round functions for the SHA-256 byte stream hasher.
// Used by shs_core and sha256_byte_stream_hasher; depends on nothing else.
package shs_pkg;

	// Input word: one message byte and its flags
	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       end_of_message;
	} shs_msg_t;

	// Output word: the digest, most significant word first
	typedef struct packed {
		logic [31:0] digest_word_0;
		logic [31:0] digest_word_1;
		logic [31:0] digest_word_2;
		logic [31:0] digest_word_3;
		logic [31:0] digest_word_4;
		logic [31:0] digest_word_5;
		logic [31:0] digest_word_6;
		logic [31:0] digest_word_7;
	} shs_dig_t;

	// Commands from the sequencer to the compression core
	typedef struct packed {
		logic       load;
		logic [7:0] load_byte;
		logic       start;
		logic       reinit;
	} shs_cmd_t;

	// Status from the compression core
	typedef struct packed {
		logic busy;
		logic done;
	} shs_sts_t;

	typedef enum logic [1:0] {
		CORE_IDLE,
		CORE_ROUND,
		CORE_FOLD
	} shs_core_state_t;

	typedef enum logic [2:0] {
		SEQ_IDLE,
		SEQ_PAD,
		SEQ_KICK,
		SEQ_HASH,
		SEQ_EMIT
	} shs_seq_state_t;

	localparam logic [7:0]  PAD_MARK  = 8'h80;
	localparam logic [5:0]  LEN_POS   = 6'd56;
	localparam logic [5:0]  LAST_POS  = 6'd63;
	localparam logic [5:0]  LAST_RND  = 6'd63;
	localparam logic [63:0] BYTE_BITS = 64'd8;

	localparam logic [31:0] INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

	function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
			input logic [31:0] g);
		return (e & f) ^ (~e & g);
	endfunction

	function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] c);
		return (a & b) ^ (a & c) ^ (b & c);
	endfunction

endpackage

### rtl/shs_core.sv
// SHA-256 compression core: 16-word schedule window, one round per cycle, chain words.
// Depends on shs_pkg for the command/status structs, round constants and functions.
module shs_core (
	input  logic                clk,
	input  logic                arst_n,
	input  shs_pkg::shs_cmd_t   cmd,
	output shs_pkg::shs_sts_t   sts,
	output logic [7:0][31:0]    chain
);
	import shs_pkg::*;

	shs_core_state_t state_q, state_d;
	logic [5:0]      rnd_q;
	logic [31:0]     w_q [16];
	logic [31:0]     v_q [8];
	logic [31:0]     h_q [8];
	logic [31:0]     t1, t2, w_next;

	// Sequence start, 64 rounds and the fold into the chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CORE_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			CORE_IDLE: begin
				if (cmd.start) begin
					state_d = CORE_ROUND;
				end
			end
			CORE_ROUND: begin
				if (rnd_q == LAST_RND) begin
					state_d = CORE_FOLD;
				end
			end
			CORE_FOLD: begin
				state_d = CORE_IDLE;
			end
			default: begin
				state_d = CORE_IDLE;
			end
		endcase
	end

	assign sts.busy = (state_q != CORE_IDLE);
	assign sts.done = (state_q == CORE_FOLD);

	// Round counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_q <= '0;
		end else if (state_q == CORE_ROUND) begin
			rnd_q <= rnd_q + 6'd1;
		end else begin
			rnd_q <= '0;
		end
	end

	// Round arithmetic and next schedule word
	assign t1 = v_q[7] + big_sigma1(v_q[4]) + choose(v_q[4], v_q[5], v_q[6])
		+ ROUND_K[rnd_q] + w_q[0];
	assign t2 = big_sigma0(v_q[0]) + majority(v_q[0], v_q[1], v_q[2]);
	assign w_next = small_sigma1(w_q[14]) + w_q[9] + small_sigma0(w_q[1]) + w_q[0];

	// Schedule window: shift bytes in while loading, shift words out while hashing
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= {w_q[i][23:0], w_q[i+1][31:24]};
			end
			w_q[15] <= {w_q[15][23:0], cmd.load_byte};
		end else if (state_q == CORE_ROUND) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= w_next;
		end
	end

	// Working variables
	always_ff @(posedge clk) begin
		if (state_q == CORE_IDLE && cmd.start) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= h_q[i];
			end
		end else if (state_q == CORE_ROUND) begin
			v_q[0] <= t1 + t2;
			v_q[1] <= v_q[0];
			v_q[2] <= v_q[1];
			v_q[3] <= v_q[2];
			v_q[4] <= v_q[3] + t1;
			v_q[5] <= v_q[4];
			v_q[6] <= v_q[5];
			v_q[7] <= v_q[6];
		end
	end

	// Chain words: fold after the last round, return to the initial values on request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= INIT_H[i];
			end
		end else if (cmd.reinit) begin
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= INIT_H[i];
			end
		end else if (state_q == CORE_FOLD) begin
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= h_q[i] + v_q[i];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			chain[7-i] = h_q[i];
		end
	end

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> state_q == CORE_IDLE)
		else $error("byte loaded while the core is hashing");

	a_fold_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == CORE_FOLD |-> $past(state_q) == CORE_ROUND && $past(rnd_q) == LAST_RND)
		else $error("fold without a full set of rounds");

	a_rnd_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == CORE_IDLE && cmd.start) |=> rnd_q == 6'd0)
		else $error("round counter not cleared at start");

endmodule

### rtl/sha256_byte_stream_hasher.sv
// SHA-256 byte stream hasher: one byte per cycle into the schedule window, padding and digest;
// input is taken only while idle. A full 64-byte block stalls input through the kick, the
// 64 rounds of the single round unit in shs_core and the fold.
// End of message: padding bytes fill the block and it is hashed (twice when the length spills),
// then the digest register is loaded. Reset: chain to the initial hash values, fill and bit
// count to zero, no digest pending.
module sha256_byte_stream_hasher (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              msg_valid,
	output logic              msg_stall,
	input  shs_pkg::shs_msg_t msg,
	output logic              dig_valid,
	input  logic              dig_stall,
	output shs_pkg::shs_dig_t dig
);
	import shs_pkg::*;

	shs_seq_state_t   state_q, state_d;
	shs_cmd_t         cmd;
	shs_sts_t         sts;
	logic [7:0][31:0] chain;
	logic [5:0]       fill_q;
	logic [63:0]      len_q;
	logic             end_q, fin_q, mark_q, last_q;
	logic             msg_take, len_byte, emit_go;
	logic [7:0]       pad_byte;

	shs_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.chain  (chain)
	);

	assign msg_stall = (state_q != SEQ_IDLE);
	assign msg_take  = msg_valid && (state_q == SEQ_IDLE);
	assign emit_go   = !dig_valid || !dig_stall;

	// Pick the padding word: marker, zeros, then the bit count high byte first
	assign len_byte = mark_q && last_q && (fill_q >= LEN_POS);
	assign pad_byte = !mark_q ? PAD_MARK : (len_byte ? len_q[63:56] : 8'h00);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and core commands
	always_comb begin
		state_d       = state_q;
		cmd.load      = 1'b0;
		cmd.load_byte = msg.data_byte;
		cmd.start     = 1'b0;
		cmd.reinit    = 1'b0;
		unique case (state_q)
			SEQ_IDLE: begin
				if (msg_take) begin
					cmd.load = msg.byte_present;
					if (msg.byte_present && fill_q == LAST_POS) begin
						state_d = SEQ_KICK;
					end else if (msg.end_of_message) begin
						state_d = SEQ_PAD;
					end
				end
			end
			SEQ_PAD: begin
				cmd.load      = 1'b1;
				cmd.load_byte = pad_byte;
				if (fill_q == LAST_POS) begin
					state_d = SEQ_KICK;
				end
			end
			SEQ_KICK: begin
				cmd.start = 1'b1;
				state_d   = SEQ_HASH;
			end
			SEQ_HASH: begin
				if (sts.done) begin
					if (fin_q) begin
						state_d = last_q ? SEQ_EMIT : SEQ_PAD;
					end else if (end_q) begin
						state_d = SEQ_PAD;
					end else begin
						state_d = SEQ_IDLE;
					end
				end
			end
			SEQ_EMIT: begin
				if (emit_go) begin
					cmd.reinit = 1'b1;
					state_d    = SEQ_IDLE;
				end
			end
			default: begin
				state_d = SEQ_IDLE;
			end
		endcase
	end

	// Fill count, bit count and finish flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			len_q  <= '0;
			end_q  <= 1'b0;
			fin_q  <= 1'b0;
			mark_q <= 1'b0;
			last_q <= 1'b0;
		end else begin
			unique case (state_q)
				SEQ_IDLE: begin
					if (msg_take) begin
						end_q <= msg.end_of_message;
						if (msg.byte_present) begin
							fill_q <= fill_q + 6'd1;
							len_q  <= len_q + BYTE_BITS;
						end
						if (msg.end_of_message && !(msg.byte_present && fill_q == LAST_POS)) begin
							fin_q  <= 1'b1;
							mark_q <= 1'b0;
						end
					end
				end
				SEQ_PAD: begin
					fill_q <= fill_q + 6'd1;
					mark_q <= 1'b1;
					if (!mark_q) begin
						last_q <= (fill_q < LEN_POS);
					end
					if (len_byte) begin
						len_q <= {len_q[55:0], 8'h00};
					end
				end
				SEQ_HASH: begin
					if (sts.done && !fin_q && end_q) begin
						fin_q  <= 1'b1;
						mark_q <= 1'b0;
					end else if (sts.done && fin_q && !last_q) begin
						last_q <= 1'b1;
					end
				end
				SEQ_EMIT: begin
					if (emit_go) begin
						len_q  <= '0;
						end_q  <= 1'b0;
						fin_q  <= 1'b0;
						mark_q <= 1'b0;
						last_q <= 1'b0;
						fill_q <= '0;
					end
				end
				default: begin
					fill_q <= fill_q;
				end
			endcase
		end
	end

	// Digest register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dig_valid <= 1'b0;
		end else if (state_q == SEQ_EMIT && emit_go) begin
			dig_valid <= 1'b1;
		end else if (!dig_stall) begin
			dig_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == SEQ_EMIT && emit_go) begin
			dig <= chain;
		end
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> !sts.busy)
		else $error("core started while busy");

	a_done_in_hash: assert property (@(posedge clk) disable iff (!arst_n)
		sts.done |-> state_q == SEQ_HASH)
		else $error("core finished outside the hash wait");

	a_load_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !sts.busy)
		else $error("word loaded while the core is hashing");

	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SEQ_EMIT && emit_go) |=> dig_valid && fill_q == 6'd0)
		else $error("digest not presented after emit");

endmodule

### tb/sv/tb.sv
// Self-checking testbench for sha256_byte_stream_hasher: directed rows, then random messages.
// Depends on shs_pkg for the word types; carries its own SHA-256 predictor.
`timescale 1ns / 1ps

module tb;
	import shs_pkg::*;

	localparam int WANT_ITEMS      = 1350;
	localparam int WANT_MESSAGES   = 20;
	localparam int CALM_ITEMS      = 1150;
	localparam int PRESSURE_AFTER  = 10;
	localparam int PRESSURE_CYCLES = 1500;
	localparam int TAIL_CYCLES     = 400;
	localparam int WATCHDOG_LIMIT  = 6000;

	localparam shs_dig_t EMPTY_DIGEST =
		256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
	localparam shs_dig_t ABC_DIGEST =
		256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

	localparam logic [31:0] SHA_IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] SHA_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	// Directed row: byte, present flag, end flag, whether the digest is typed in, digest
	typedef struct packed {
		logic [7:0] data;
		logic       present;
		logic       last;
		logic       known;
		shs_dig_t   digest;
	} dir_row_t;

	localparam int DIR_ROWS = 13;
	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},  // empty message straight after reset
		{8'h61, 1'b1, 1'b0, 1'b0, 256'h0},
		{8'h5a, 1'b0, 1'b0, 1'b0, 256'h0},        // data without its present flag
		{8'h62, 1'b1, 1'b0, 1'b0, 256'h0},
		{8'h00, 1'b0, 1'b0, 1'b0, 256'h0},        // no byte and no end
		{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},    // byte and end together
		{8'h00, 1'b1, 1'b0, 1'b0, 256'h0},
		{8'hff, 1'b1, 1'b0, 1'b0, 256'h0},
		{8'ha5, 1'b0, 1'b1, 1'b0, 256'h0},        // end alone, data ignored
		{8'hff, 1'b1, 1'b1, 1'b0, 256'h0},
		{8'h00, 1'b1, 1'b1, 1'b0, 256'h0},
		{8'hff, 1'b0, 1'b0, 1'b0, 256'h0},
		{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST}   // empty again once state has cleared
	};

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     msg_valid = 1'b0;
	logic     msg_stall;
	shs_msg_t msg = '0;
	logic     dig_valid;
	logic     dig_stall = 1'b0;
	shs_dig_t dig;

	// Typed-in digest travels beside the word it belongs to
	logic     drv_known = 1'b0;
	shs_dig_t drv_known_digest = '0;

	// Predictor state
	logic [31:0] chain_h [8];
	logic [7:0]  blk [64];
	int unsigned fill;
	logic [63:0] bits_done;
	shs_dig_t    expected_digests [$];

	int  items_sent = 0;
	int  msgs_sent = 0;
	int  dig_count = 0;
	int  errors = 0;
	int  quiet_cycles = 0;
	bit  calm = 1'b0;
	bit  pressure_done = 1'b0;

	sha256_byte_stream_hasher dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_stall (msg_stall),
		.msg       (msg),
		.dig_valid (dig_valid),
		.dig_stall (dig_stall),
		.dig       (dig)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic hasher_clear();
		int i;
		for (i = 0; i < 8; i++) chain_h[i] = SHA_IV[i];
		for (i = 0; i < 64; i++) blk[i] = 8'h00;
		fill = 0;
		bits_done = '0;
	endtask

	// Fold the 64-byte buffer into the chaining words
	task automatic sha_compress();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] s0, s1, t1, t2;
		int i;
		for (i = 0; i < 16; i++)
			w[i] = {blk[4 * i], blk[4 * i + 1], blk[4 * i + 2], blk[4 * i + 3]};
		for (i = 16; i < 64; i++) begin
			s0 = rotr(w[i - 15], 7) ^ rotr(w[i - 15], 18) ^ (w[i - 15] >> 3);
			s1 = rotr(w[i - 2], 17) ^ rotr(w[i - 2], 19) ^ (w[i - 2] >> 10);
			w[i] = s1 + w[i - 7] + s0 + w[i - 16];
		end
		for (i = 0; i < 8; i++) v[i] = chain_h[i];
		for (i = 0; i < 64; i++) begin
			t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) +
				((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[i] + w[i];
			t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) +
				((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (i = 0; i < 8; i++) chain_h[i] = chain_h[i] + v[i];
	endtask

	// Take one accepted word; on end of message queue the expected digest
	task automatic hash_absorb(input shs_msg_t m, input logic known, input shs_dig_t typed);
		logic [63:0] total;
		shs_dig_t    digest;
		int i;
		if (m.byte_present) begin
			blk[fill] = m.data_byte;
			fill++;
			if (fill == 64) begin
				sha_compress();
				bits_done = bits_done + 64'd512;
				fill = 0;
			end
		end
		if (m.end_of_message) begin
			total = bits_done + 64'(fill) * 64'd8;
			blk[fill] = 8'h80;
			fill++;
			// no room for the length: pad out and spill into a second block
			if (fill > 56) begin
				while (fill < 64) begin
					blk[fill] = 8'h00;
					fill++;
				end
				sha_compress();
				fill = 0;
			end
			while (fill < 56) begin
				blk[fill] = 8'h00;
				fill++;
			end
			for (i = 0; i < 8; i++) blk[56 + i] = total[63 - 8 * i -: 8];
			sha_compress();
			for (i = 0; i < 8; i++) digest[255 - 32 * i -: 32] = chain_h[i];
			expected_digests.push_back(known ? typed : digest);
			hasher_clear();
		end
	endtask

	// Offer one word and hold it until accepted
	task automatic send_item(input logic [7:0] data, input logic present, input logic last,
			input logic known, input shs_dig_t typed);
		if (!calm && $urandom_range(0, 5) == 0) begin
			msg_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		msg_valid <= 1'b1;
		msg <= '{data_byte: data, byte_present: present, end_of_message: last};
		drv_known <= known;
		drv_known_digest <= typed;
		@(posedge clk);
		while (msg_stall) @(posedge clk);
	endtask

	// Mostly short messages, many on the padding boundaries, a few long ones
	function automatic int pick_length();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 5)
			return $urandom_range(0, 20);
		if (sel < 8) begin
			case ($urandom_range(0, 9))
				0: return 55;
				1: return 56;
				2: return 57;
				3: return 63;
				4: return 64;
				5: return 65;
				6: return 119;
				7: return 120;
				8: return 127;
				default: return 128;
			endcase
		end
		return $urandom_range(0, 200);
	endfunction

	// One random message, end on the last byte or as a word of its own, with noise between
	task automatic send_message(input int len);
		bit split_end;
		int i;
		split_end = (len == 0) || ($urandom_range(0, 1) == 1);
		for (i = 0; i < len; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, '0);
				items_sent++;
			end
			send_item(8'($urandom_range(0, 255)), 1'b1, (!split_end && i == len - 1), 1'b0,
				'0);
			items_sent++;
		end
		if (split_end) begin
			send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, '0);
			items_sent++;
		end
		msgs_sent++;
		calm = (items_sent >= CALM_ITEMS);
	endtask

	// Stimulus
	initial begin
		int row;
		hasher_clear();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (row = 0; row < DIR_ROWS; row++)
			send_item(DIRECTED[row].data, DIRECTED[row].present, DIRECTED[row].last,
				DIRECTED[row].known, DIRECTED[row].digest);
		while (items_sent < WANT_ITEMS || msgs_sent < WANT_MESSAGES)
			send_message(pick_length());
		msg_valid <= 1'b0;
		// drain, then let the block settle
		while (expected_digests.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Receiver: random stalls, one long hold-off to back the block up
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!pressure_done && dig_count >= PRESSURE_AFTER) begin
				dig_stall <= 1'b1;
				repeat (PRESSURE_CYCLES) @(posedge clk);
				pressure_done = 1'b1;
				dig_stall <= 1'b0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				dig_stall <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				dig_stall <= 1'b0;
			end else begin
				dig_stall <= 1'b0;
			end
		end
	end

	// Predict on every accepted input word, check every accepted digest
	always @(posedge clk) begin : monitor
		shs_dig_t want;
		int k;
		if (arst_n) begin
			if (msg_valid && !msg_stall)
				hash_absorb(msg, drv_known, drv_known_digest);
			if (dig_valid && !dig_stall) begin
				dig_count++;
				if (expected_digests.size() == 0) begin
					$display("%0t: digest with none expected, got %h", $time, dig);
					errors++;
				end else begin
					want = expected_digests.pop_front();
					for (k = 0; k < 8; k++)
						if (dig[255 - 32 * k -: 32] !== want[255 - 32 * k -: 32]) begin
							$display("%0t: digest_word_%0d expected %h got %h", $time, k,
								want[255 - 32 * k -: 32], dig[255 - 32 * k -: 32]);
							errors++;
						end
				end
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((msg_valid && !msg_stall) || (dig_valid && !dig_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

endmodule
